FILE: sv/mssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssc_pkg
// Shared types and constants for the multi-signature byte scanner.
// ----------------------------------------------------------------------------
package mssc_pkg;

    localparam int NUM_SIG  = 16;
    localparam int MAX_LEN  = 64;
    localparam int MAX_SCAN = 65536;

    localparam int SIDX_W = (NUM_SIG > 1) ? $clog2(NUM_SIG) : 1;
    localparam int K_W    = $clog2(NUM_SIG + 1);
    localparam int HIDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W  = $clog2(MAX_SCAN + 1);
    localparam int SIG_W  = MAX_LEN * 8;

    typedef enum logic [1:0] {
        ACT_WR_BYTE = 2'd0,
        ACT_SET_LEN = 2'd1,
        ACT_SCAN    = 2'd2,
        ACT_NEW_BUF = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [3:0]  sig_slot;
        logic [5:0]  byte_pos;
        logic [7:0]  value;
        logic [6:0]  new_length;
    } t_in_item;

    typedef struct packed {
        logic [15:0] match_offset;
        logic [3:0]  match_slot;
        logic [6:0]  match_length;
        logic        last;
    } t_out_item;

    typedef logic [MAX_LEN-1:0][7:0] t_hist;

endpackage
`default_nettype wire

FILE: sv/mssc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

FILE: sv/mssc_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssc_match
// Compares the newest history bytes with one signature word, up to the
// signature length.
// ----------------------------------------------------------------------------
module mssc_match (
    input  wire logic [mssc_pkg::SIG_W-1:0]  i_sig,
    input  wire mssc_pkg::t_hist             i_hist,
    input  wire logic [mssc_pkg::LEN_W-1:0]  i_len,
    output logic                             o_equal
);

    logic [mssc_pkg::MAX_LEN-1:0] w_eq;

    // history entry a is the byte scanned a items ago; it meets signature
    // byte len-1-a
    always_comb begin
        logic [mssc_pkg::HIDX_W-1:0] sidx;
        for (int a = 0; a < mssc_pkg::MAX_LEN; a++) begin
            sidx = mssc_pkg::HIDX_W'(i_len - mssc_pkg::LEN_W'(a) - mssc_pkg::LEN_W'(1));
            // ages at or beyond the signature length always agree
            w_eq[a] = (mssc_pkg::LEN_W'(a) >= i_len) ||
                      (i_hist[a] == i_sig[{sidx, 3'b000} +: 8]);
        end
    end

    assign o_equal = &w_eq;

endmodule
`default_nettype wire

FILE: sv/multi_signature_byte_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_signature_byte_scanner
// Scans a byte stream against up to sixteen loaded signatures.
// ----------------------------------------------------------------------------
// Signatures live in one RAM word per slot. A scanned byte is accepted, then
// the slots are read and compared, one slot per cycle through the signature
// RAM with its registered read data, and the matches are emitted one at a
// time, paced by the output stall. Writing a signature byte is a
// read-modify-write of the slot word through the LOAD_RD and LOAD_WR states;
// setting a length or starting a new buffer leaves the scanner idle and
// ready for the next item. Matches of one byte come out in slot order, the
// last one flagged.
module multi_signature_byte_scanner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mssc_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mssc_pkg::t_out_item     o_out_data
);

    localparam int SI = mssc_pkg::SIDX_W;
    localparam int PW = mssc_pkg::POS_W;
    localparam int LW = mssc_pkg::LEN_W;

    mssc_pkg::t_state   r_state, n_state;
    mssc_pkg::t_in_item r_item;
    logic [LW-1:0]      r_len [mssc_pkg::NUM_SIG];
    logic [PW-1:0]      r_nas [mssc_pkg::NUM_SIG];
    mssc_pkg::t_hist    r_hist;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_p1;
    logic [mssc_pkg::K_W-1:0] r_k;
    logic               r_cmp_v;
    logic [SI-1:0]      r_kb;
    logic [mssc_pkg::NUM_SIG-1:0] r_hits;
    logic               r_out_valid;
    mssc_pkg::t_out_item r_out;

    logic                       w_accept;
    logic                       w_we;
    logic [SI-1:0]              w_addr;
    logic [mssc_pkg::SIG_W-1:0] w_wdata;
    logic [mssc_pkg::SIG_W-1:0] w_rdata;
    logic                       w_equal;
    logic [LW-1:0]              w_len;
    logic [PW-1:0]              w_start;
    logic                       w_hit;
    logic                       w_can_load;
    logic [SI-1:0]              w_e;
    logic [mssc_pkg::NUM_SIG-1:0] w_rest;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != mssc_pkg::ST_IDLE);
    assign w_can_load = !r_out_valid || !i_out_stall;

    mssc_ram #(
        .WIDTH (mssc_pkg::SIG_W),
        .DEPTH (1 << SI)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // byte merge for signature loads
    always_comb begin
        for (int j = 0; j < mssc_pkg::MAX_LEN; j++) begin
            w_wdata[j*8 +: 8] = (32'(r_item.byte_pos) == j) ? r_item.value
                                                            : w_rdata[j*8 +: 8];
        end
    end

    assign w_we   = (r_state == mssc_pkg::ST_LOAD_WR);
    assign w_addr = (r_state == mssc_pkg::ST_SCAN) ? r_k[SI-1:0]
                                                   : SI'(r_item.sig_slot);

    // candidate start for the slot under compare
    assign w_len   = r_len[r_kb];
    assign w_start = r_p1 - PW'(w_len);

    mssc_match u_match (
        .i_sig      (w_rdata),
        .i_hist     (r_hist),
        .i_len      (w_len),
        .o_equal    (w_equal)
    );

    assign w_hit = r_cmp_v && (w_len != '0) && (r_p1 >= PW'(w_len)) &&
                   (w_start >= r_nas[r_kb]) && w_equal;

    // lowest pending hit
    always_comb begin
        w_e = '0;
        for (int i = mssc_pkg::NUM_SIG - 1; i >= 0; i--) begin
            if (r_hits[i]) begin
                w_e = SI'(i);
            end
        end
        w_rest = r_hits;
        w_rest[w_e] = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mssc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.action)
                        mssc_pkg::ACT_WR_BYTE: begin
                            if (32'(i_in_data.sig_slot) < mssc_pkg::NUM_SIG &&
                                32'(i_in_data.byte_pos) < mssc_pkg::MAX_LEN) begin
                                n_state = mssc_pkg::ST_LOAD_RD;
                            end
                        end
                        mssc_pkg::ACT_SCAN: begin
                            if (32'(r_pos) < mssc_pkg::MAX_SCAN) begin
                                n_state = mssc_pkg::ST_SCAN;
                            end
                        end
                        default: n_state = mssc_pkg::ST_IDLE;
                    endcase
                end
            end
            mssc_pkg::ST_LOAD_RD: n_state = mssc_pkg::ST_LOAD_WR;
            mssc_pkg::ST_LOAD_WR: n_state = mssc_pkg::ST_IDLE;
            mssc_pkg::ST_SCAN: begin
                if (32'(r_k) == mssc_pkg::NUM_SIG) begin
                    n_state = mssc_pkg::ST_EMIT;
                end
            end
            mssc_pkg::ST_EMIT: begin
                if (r_hits == '0) begin
                    n_state = mssc_pkg::ST_IDLE;
                end else if (w_can_load && w_rest == '0) begin
                    n_state = mssc_pkg::ST_IDLE;
                end
            end
            default: n_state = mssc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mssc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_hist      <= '0;
            r_cmp_v     <= 1'b0;
            r_k         <= '0;
            r_hits      <= '0;
            for (int i = 0; i < mssc_pkg::NUM_SIG; i++) begin
                r_len[i] <= '0;
                r_nas[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == mssc_pkg::ST_EMIT && r_hits != '0 && w_can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                mssc_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_in_data;
                        case (i_in_data.action)
                            mssc_pkg::ACT_SET_LEN: begin
                                if (32'(i_in_data.sig_slot) < mssc_pkg::NUM_SIG) begin
                                    r_len[SI'(i_in_data.sig_slot)] <=
                                        (32'(i_in_data.new_length) > mssc_pkg::MAX_LEN)
                                        ? LW'(mssc_pkg::MAX_LEN)
                                        : LW'(i_in_data.new_length);
                                end
                            end
                            mssc_pkg::ACT_NEW_BUF: begin
                                r_pos  <= '0;
                                r_hist <= '0;
                                for (int i = 0; i < mssc_pkg::NUM_SIG; i++) begin
                                    r_nas[i] <= '0;
                                end
                            end
                            mssc_pkg::ACT_SCAN: begin
                                if (32'(r_pos) < mssc_pkg::MAX_SCAN) begin
                                    // newest byte enters at entry zero
                                    r_hist  <= {r_hist[mssc_pkg::MAX_LEN-2:0],
                                                i_in_data.value};
                                    r_pos   <= r_pos + PW'(1);
                                    r_p1    <= r_pos + PW'(1);
                                    r_k     <= '0;
                                    r_cmp_v <= 1'b0;
                                    r_hits  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                mssc_pkg::ST_SCAN: begin
                    r_cmp_v <= (32'(r_k) < mssc_pkg::NUM_SIG);
                    r_kb    <= r_k[SI-1:0];
                    if (32'(r_k) < mssc_pkg::NUM_SIG) begin
                        r_k <= r_k + mssc_pkg::K_W'(1);
                    end
                    if (w_hit) begin
                        r_hits[r_kb] <= 1'b1;
                        r_nas[r_kb]  <= r_p1;
                    end
                end
                mssc_pkg::ST_EMIT: begin
                    r_cmp_v <= 1'b0;
                    if (r_hits != '0 && w_can_load) begin
                        r_out.match_offset <= 16'(r_p1 - PW'(r_len[w_e]));
                        r_out.match_slot   <= 4'(w_e);
                        r_out.match_length <= 7'(r_len[w_e]);
                        r_out.last         <= (w_rest == '0);
                        r_hits             <= w_rest;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: sv/mssc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssc_checker
// Port-level checks for the multi-signature byte scanner.
// ----------------------------------------------------------------------------
module mssc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire mssc_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire mssc_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // length writes and buffer restarts leave the input unstalled in the next cycle
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in_data.action == mssc_pkg::ACT_SET_LEN ||
         i_in_data.action == mssc_pkg::ACT_NEW_BUF) |=> !o_in_stall)
        else $error("single-cycle item held the input");

    // a non-final match is followed straight away by the next one
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a match burst");

    // results never show a zero length
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.match_length != 7'd0)
        else $error("zero-length match");

endmodule

bind multi_signature_byte_scanner mssc_checker u_mssc_checker (.*);
`default_nettype wire
